[rtl/rigf_pkg.sv]
// shared types and constants of the region invert / gray filter
// no dependencies
`timescale 1ns / 1ps

package rigf_pkg;

    localparam int MAX_DIM_DEFAULT = 4096;

    // configuration port
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int DIM_W       = 13;
    localparam int BOUND_W     = 14;

    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_REGION_LEFT   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_REGION_TOP    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_REGION_RIGHT  = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_REGION_BOTTOM = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_INVERT_ENABLE = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_GRAY_ENABLE   = 3'd7;

    localparam logic [DIM_W-1:0] WIDTH_RESET  = 13'd640;
    localparam logic [DIM_W-1:0] HEIGHT_RESET = 13'd480;

    // bt.601 luma weights in q16
    localparam logic [15:0] LUMA_R     = 16'd19595;
    localparam logic [15:0] LUMA_G     = 16'd38470;
    localparam logic [15:0] LUMA_B     = 16'd7471;
    localparam logic [15:0] LUMA_ROUND = 16'd32768;
    localparam logic [7:0]  PIX_MAX    = 8'd255;

    // queue between front and back, depth is a power of two
    localparam int Q_DEPTH = 2;

    typedef struct packed {
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
    } pix_in_t;

    typedef struct packed {
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
        logic       line_end;
        logic       frame_end;
    } pix_out_t;

    // classified word handed from front to back
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       do_invert;
        logic       do_gray;
        logic       line_end;
        logic       frame_end;
    } job_t;

endpackage

[rtl/rigf_front.sv]
// front of the filter: configuration registers, raster counters, classification
// depends on rigf_pkg
`timescale 1ns / 1ps

module rigf_front #(
    parameter int MAX_DIM = rigf_pkg::MAX_DIM_DEFAULT
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [rigf_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [rigf_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  rigf_pkg::pix_in_t                   s_data,
    output logic                                push_valid,
    input  logic                                push_ready,
    output rigf_pkg::job_t                      push_data
);
    import rigf_pkg::*;

    localparam int CW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int DW = $clog2(MAX_DIM + 1);

    logic [DIM_W-1:0]          width_reg;
    logic [DIM_W-1:0]          height_reg;
    logic signed [BOUND_W-1:0] left_reg;
    logic signed [BOUND_W-1:0] top_reg;
    logic signed [BOUND_W-1:0] right_reg;
    logic signed [BOUND_W-1:0] bottom_reg;
    logic                      invert_reg;
    logic                      gray_reg;

    logic [CW-1:0] col_reg, col_next;
    logic [CW-1:0] row_reg, row_next;

    logic [DW-1:0] w_eff, h_eff;
    logic [DW-1:0] lx, rx, ty, by;
    logic [DW-1:0] min_x, max_x, min_y, max_y;
    logic [DW-1:0] col_ext, row_ext;
    logic          in_region, lend, fend, take;

    function automatic logic [DW-1:0] eff_dim(input logic [DIM_W-1:0] d);
        logic [31:0] d32;
        d32 = 32'(d);
        if (d32 == 32'd0) begin
            return DW'(1);
        end else if (d32 > 32'(MAX_DIM)) begin
            return DW'(MAX_DIM);
        end
        return d32[DW-1:0];
    endfunction

    function automatic logic [DW-1:0] clamp_bound(input logic signed [BOUND_W-1:0] v,
                                                  input logic [DW-1:0] lim);
        logic signed [31:0] vs;
        logic signed [31:0] ls;
        vs = 32'(v);
        ls = signed'(32'(lim));
        if (vs < 0) begin
            return '0;
        end else if (vs > ls) begin
            return lim;
        end
        return vs[DW-1:0];
    endfunction

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
            left_reg   <= '0;
            top_reg    <= '0;
            right_reg  <= '0;
            bottom_reg <= '0;
            invert_reg <= 1'b0;
            gray_reg   <= 1'b0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_IMAGE_WIDTH:   width_reg  <= cfg_data[DIM_W-1:0];
                REG_IMAGE_HEIGHT:  height_reg <= cfg_data[DIM_W-1:0];
                REG_REGION_LEFT:   left_reg   <= signed'(cfg_data[BOUND_W-1:0]);
                REG_REGION_TOP:    top_reg    <= signed'(cfg_data[BOUND_W-1:0]);
                REG_REGION_RIGHT:  right_reg  <= signed'(cfg_data[BOUND_W-1:0]);
                REG_REGION_BOTTOM: bottom_reg <= signed'(cfg_data[BOUND_W-1:0]);
                REG_INVERT_ENABLE: invert_reg <= cfg_data[0];
                REG_GRAY_ENABLE:   gray_reg   <= cfg_data[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        w_eff = eff_dim(width_reg);
        h_eff = eff_dim(height_reg);
        lx    = clamp_bound(left_reg, w_eff);
        rx    = clamp_bound(right_reg, w_eff);
        ty    = clamp_bound(top_reg, h_eff);
        by    = clamp_bound(bottom_reg, h_eff);
        // reversed bounds are swapped
        min_x = (lx > rx) ? rx : lx;
        max_x = (lx > rx) ? lx : rx;
        min_y = (ty > by) ? by : ty;
        max_y = (ty > by) ? ty : by;
        col_ext = DW'(col_reg);
        row_ext = DW'(row_reg);
        in_region = (col_ext >= min_x) && (col_ext < max_x)
                 && (row_ext >= min_y) && (row_ext < max_y);
        // a counter past its last value after a size change also ends the line
        lend = col_ext >= (w_eff - DW'(1));
        fend = lend && (row_ext >= (h_eff - DW'(1)));
    end

    assign take       = s_valid && push_ready;
    assign s_ready    = push_ready;
    assign push_valid = s_valid;

    always_comb begin
        push_data.red       = s_data.red_in;
        push_data.green     = s_data.green_in;
        push_data.blue      = s_data.blue_in;
        push_data.do_invert = in_region && invert_reg;
        push_data.do_gray   = in_region && gray_reg;
        push_data.line_end  = lend;
        push_data.frame_end = fend;
    end

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (take) begin
            if (lend) begin
                col_next = '0;
                row_next = fend ? '0 : row_reg + CW'(1);
            end else begin
                col_next = col_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

[rtl/rigf_queue.sv]
// short queue of classified words between front and back
// depends on rigf_pkg
`timescale 1ns / 1ps

module rigf_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push_valid,
    output logic           push_ready,
    input  rigf_pkg::job_t push_data,
    output logic           pop_valid,
    input  logic           pop_ready,
    output rigf_pkg::job_t pop_data
);
    import rigf_pkg::*;

    localparam int PW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int NW = $clog2(Q_DEPTH + 1);

    job_t          mem_reg [Q_DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [NW-1:0] count_reg, count_next;
    logic          do_push, do_pop;

    assign push_ready = count_reg != NW'(Q_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        count_next = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + NW'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - NW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + PW'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + PW'(1);
            end
        end
    end

endmodule

[rtl/rigf_back.sv]
// back of the filter: inversion, luma products, luma sum and output register
// depends on rigf_pkg
`timescale 1ns / 1ps

module rigf_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               pop_valid,
    output logic               pop_ready,
    input  rigf_pkg::job_t     pop_data,
    output logic               m_valid,
    input  logic               m_ready,
    output rigf_pkg::pix_out_t m_data
);
    import rigf_pkg::*;

    logic       v1_reg, v2_reg;
    logic       adv1, adv2;
    logic [7:0] r_inv, g_inv, b_inv;

    logic [7:0]  r1_reg, g1_reg, b1_reg;
    logic [23:0] pr_reg, pg_reg, pb_reg;
    logic        gray1_reg, lend1_reg, fend1_reg;

    logic [25:0] luma_sum;
    logic [9:0]  luma_q;
    logic [7:0]  luma;
    pix_out_t    out_reg, out_next;

    // each stage moves when the one after it is empty or moving
    assign adv2      = !v2_reg || m_ready;
    assign adv1      = !v1_reg || adv2;
    assign pop_ready = adv1;

    always_comb begin
        r_inv = pop_data.do_invert ? PIX_MAX - pop_data.red   : pop_data.red;
        g_inv = pop_data.do_invert ? PIX_MAX - pop_data.green : pop_data.green;
        b_inv = pop_data.do_invert ? PIX_MAX - pop_data.blue  : pop_data.blue;
    end

    always_ff @(posedge aclk) begin
        if (adv1 && pop_valid) begin
            r1_reg    <= r_inv;
            g1_reg    <= g_inv;
            b1_reg    <= b_inv;
            pr_reg    <= 24'(LUMA_R) * 24'(r_inv);
            pg_reg    <= 24'(LUMA_G) * 24'(g_inv);
            pb_reg    <= 24'(LUMA_B) * 24'(b_inv);
            gray1_reg <= pop_data.do_gray;
            lend1_reg <= pop_data.line_end;
            fend1_reg <= pop_data.frame_end;
        end
    end

    always_comb begin
        luma_sum = 26'(pr_reg) + 26'(pg_reg) + 26'(pb_reg) + 26'(LUMA_ROUND);
        luma_q   = luma_sum[25:16];
        luma     = (luma_q > 10'(PIX_MAX)) ? PIX_MAX : luma_q[7:0];
        out_next.red_out   = gray1_reg ? luma : r1_reg;
        out_next.green_out = gray1_reg ? luma : g1_reg;
        out_next.blue_out  = gray1_reg ? luma : b1_reg;
        out_next.line_end  = lend1_reg;
        out_next.frame_end = fend1_reg;
    end

    always_ff @(posedge aclk) begin
        if (adv2 && v1_reg) begin
            out_reg <= out_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            if (adv1) begin
                v1_reg <= pop_valid;
            end
            if (adv2) begin
                v2_reg <= v1_reg;
            end
        end
    end

    assign m_valid = v2_reg;
    assign m_data  = out_reg;

endmodule

[rtl/region_invert_gray_filter.sv]
// top level of the region invert / gray filter: front, queue and back
// depends on rigf_pkg, rigf_front, rigf_queue, rigf_back
//
//   channel | handshake             | word
//   --------+-----------------------+--------------------------------------
//   input   | s_valid / s_ready     | s_data: rgb pixel in raster order
//   output  | m_valid / m_ready     | m_data: rgb pixel, line_end, frame_end
//   config  | cfg_valid / cfg_ready | cfg_index, cfg_data (register write)
//
// one pixel per clock sustained while m_ready is high; a taken pixel passes through
// the queue register, the product stage and the luma sum into the output register
// the front classifies into a two-word queue, so s_ready only drops when the
// queue is full, which happens only when m_ready has been low
// cfg_ready is always high; aresetn is synchronous and clears counters, valid
// bits and configuration registers to their reset values; data is not reset
`timescale 1ns / 1ps

module region_invert_gray_filter #(
    parameter int MAX_DIM = rigf_pkg::MAX_DIM_DEFAULT
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [rigf_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [rigf_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  rigf_pkg::pix_in_t                s_data,
    output logic                             m_valid,
    input  logic                             m_ready,
    output rigf_pkg::pix_out_t               m_data
);
    import rigf_pkg::*;

    logic push_valid, push_ready, pop_valid, pop_ready;
    job_t push_data, pop_data;

    rigf_front #(
        .MAX_DIM (MAX_DIM)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    rigf_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    rigf_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

[rtl/rigf_checker.sv]
// port-level checks of the region invert / gray filter, bound to the top level
// depends on rigf_pkg and region_invert_gray_filter
`timescale 1ns / 1ps

module rigf_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             cfg_valid,
    input logic                             cfg_ready,
    input logic [rigf_pkg::CFG_INDEX_W-1:0] cfg_index,
    input logic [rigf_pkg::CFG_DATA_W-1:0]  cfg_data,
    input logic                             s_valid,
    input logic                             s_ready,
    input rigf_pkg::pix_in_t                s_data,
    input logic                             m_valid,
    input logic                             m_ready,
    input rigf_pkg::pix_out_t               m_data
);
    import rigf_pkg::*;

    // words taken in but not yet delivered
    logic [3:0] pending_reg;
    logic       in_take, out_take;

    assign in_take  = s_valid && s_ready;
    assign out_take = m_valid && m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= '0;
        end else if (in_take && !out_take) begin
            pending_reg <= pending_reg + 4'd1;
        end else if (out_take && !in_take) begin
            pending_reg <= pending_reg - 4'd1;
        end
    end

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("output word changed while stalled");

    a_no_invented: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> pending_reg != 4'd0)
        else $error("output word without a pixel taken in");

    a_empty_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        pending_reg == 4'd0 |-> s_ready)
        else $error("empty filter refuses a pixel");

    a_frame_on_line: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.frame_end |-> m_data.line_end)
        else $error("frame end without line end");

    a_cfg_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_valid |-> cfg_ready || (cfg_index == REG_IMAGE_WIDTH && cfg_data == '0))
        else $error("register write refused");

endmodule

bind region_invert_gray_filter rigf_checker u_rigf_checker (.*);
